/* hdl/mtrf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrf_pkg
// Shared types and constants of the Modbus TCP request framer.
// ----------------------------------------------------------------------------
package mtrf_pkg;

  localparam int unsigned FRAME_BYTES = 13;

  localparam logic [15:0] MAX_BIT_QUANTITY = 16'd2000;
  localparam logic [15:0] MAX_REG_QUANTITY = 16'd125;

  localparam logic [3:0] CMD_READ_COILS    = 4'd0;
  localparam logic [3:0] CMD_READ_DISCRETE = 4'd1;
  localparam logic [3:0] CMD_READ_HOLDING  = 4'd2;
  localparam logic [3:0] CMD_READ_INPUT    = 4'd3;
  localparam logic [3:0] CMD_WRITE_COIL    = 4'd4;
  localparam logic [3:0] CMD_WRITE_REG     = 4'd5;
  localparam logic [3:0] CMD_MULTI_COILS   = 4'd6;
  localparam logic [3:0] CMD_MULTI_REGS    = 4'd7;
  localparam logic [3:0] CMD_PAYLOAD       = 4'd8;

  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_MULTI_COILS = 8'd15;
  localparam logic [7:0] FC_MULTI_REGS  = 8'd16;

  localparam logic [15:0] LEN_SINGLE      = 16'd6;
  localparam logic [15:0] LEN_MULTI_BASE  = 16'd7;
  localparam logic [15:0] COIL_ON         = 16'hFF00;
  localparam logic [3:0]  CNT_SINGLE      = 4'd12;
  localparam logic [3:0]  CNT_MULTI       = 4'd13;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [3:0]                  cnt;
    logic                        last_fin;
    logic                        err;
  } frame_t;

  typedef struct packed {
    logic [15:0] tc;
    logic [7:0]  rem;
    logic        is_regs;
  } state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [7:0]  unit_id;
    logic [15:0] address;
    logic [15:0] quantity;
    logic [15:0] value;
  } item_t;

endpackage
`default_nettype wire

/* hdl/mtrf_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrf_decode
// Builds the byte list of one item and the next framer state.
// ----------------------------------------------------------------------------
module mtrf_decode (
  input  mtrf_pkg::item_t  item_i,
  input  mtrf_pkg::state_t state_i,
  output mtrf_pkg::frame_t frame_o,
  output mtrf_pkg::state_t state_o
);
  import mtrf_pkg::*;

  logic [7:0]  fc;
  logic        ok;
  logic        multi;
  logic [15:0] third;
  logic [15:0] count;
  logic [15:0] len;
  logic [7:0]  rem_n;

  always_comb begin
    fc    = {4'd0, item_i.command} + 8'd1;
    ok    = 1'b0;
    multi = 1'b0;
    third = item_i.quantity;
    count = '0;
    unique case (item_i.command)
      CMD_READ_COILS, CMD_READ_DISCRETE: begin
        ok = item_i.quantity <= MAX_BIT_QUANTITY;
      end
      CMD_READ_HOLDING, CMD_READ_INPUT: begin
        ok = item_i.quantity <= MAX_REG_QUANTITY;
      end
      CMD_WRITE_COIL: begin
        fc    = FC_WRITE_COIL;
        ok    = 1'b1;
        third = (item_i.value != '0) ? COIL_ON : '0;
      end
      CMD_WRITE_REG: begin
        fc    = FC_WRITE_REG;
        ok    = 1'b1;
        third = item_i.value;
      end
      CMD_MULTI_COILS: begin
        fc    = FC_MULTI_COILS;
        multi = 1'b1;
        ok    = (item_i.quantity != '0) && (item_i.quantity <= MAX_BIT_QUANTITY);
        count = {3'd0, item_i.quantity[15:3]} + {15'd0, item_i.quantity[2:0] != 3'd0};
      end
      CMD_MULTI_REGS: begin
        fc    = FC_MULTI_REGS;
        multi = 1'b1;
        ok    = (item_i.quantity != '0) && (item_i.quantity <= MAX_REG_QUANTITY);
        count = {item_i.quantity[14:0], 1'b0};
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    len   = multi ? (LEN_MULTI_BASE + count) : LEN_SINGLE;
    rem_n = (state_i.rem >= 8'd2) ? (state_i.rem - 8'd2) : 8'd0;
  end

  always_comb begin
    frame_o          = '0;
    frame_o.cnt      = 4'd1;
    frame_o.last_fin = 1'b1;
    frame_o.err      = 1'b1;
    state_o          = state_i;
    if (item_i.command == CMD_PAYLOAD) begin
      if (state_i.rem != '0) begin
        frame_o.err = 1'b0;
        if (state_i.is_regs) begin
          frame_o.bytes[0] = item_i.value[15:8];
          frame_o.bytes[1] = item_i.value[7:0];
          frame_o.cnt      = 4'd2;
          frame_o.last_fin = rem_n == '0;
          state_o.rem      = rem_n;
        end else begin
          frame_o.bytes[0] = item_i.value[7:0];
          frame_o.last_fin = state_i.rem == 8'd1;
          state_o.rem      = state_i.rem - 8'd1;
        end
      end
    end else if (item_i.command < CMD_PAYLOAD) begin
      state_o.rem     = '0;
      state_o.is_regs = 1'b0;
      if (ok) begin
        frame_o.bytes[0]  = state_i.tc[15:8];
        frame_o.bytes[1]  = state_i.tc[7:0];
        frame_o.bytes[4]  = len[15:8];
        frame_o.bytes[5]  = len[7:0];
        frame_o.bytes[6]  = item_i.unit_id;
        frame_o.bytes[7]  = fc;
        frame_o.bytes[8]  = item_i.address[15:8];
        frame_o.bytes[9]  = item_i.address[7:0];
        frame_o.bytes[10] = third[15:8];
        frame_o.bytes[11] = third[7:0];
        frame_o.bytes[12] = count[7:0];
        frame_o.cnt       = multi ? CNT_MULTI : CNT_SINGLE;
        frame_o.last_fin  = !multi;
        frame_o.err       = 1'b0;
        state_o.tc        = state_i.tc + 16'd1;
        if (multi) begin
          state_o.rem     = count[7:0];
          state_o.is_regs = item_i.command == CMD_MULTI_REGS;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/mtrf_serializer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtrf_serializer
// Holds one built frame and sends it out one byte per beat.
// ----------------------------------------------------------------------------
module mtrf_serializer (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  mtrf_pkg::frame_t frame_i,
  input  wire              frame_vld_i,
  output logic             frame_rdy_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_o,
  output logic             error_o,
  output logic             out_valid_o,
  input  wire              out_ready_i
);
  import mtrf_pkg::*;

  frame_t     frame_q;
  logic       fr_vld_q;
  logic [3:0] idx_q;
  logic       out_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       err_q;
  logic       b_adv;
  logic       last_byte;

  assign last_byte   = idx_q == (frame_q.cnt - 4'd1);
  assign b_adv       = fr_vld_q && (!out_vld_q || out_ready_i);
  assign frame_rdy_o = !fr_vld_q || (b_adv && last_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q  <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (frame_rdy_o) begin
        fr_vld_q <= frame_vld_i;
        idx_q    <= '0;
      end else if (b_adv) begin
        idx_q <= idx_q + 4'd1;
      end
      if (b_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_rdy_o && frame_vld_i) begin
      frame_q <= frame_i;
    end
    if (b_adv) begin
      byte_q <= frame_q.bytes[idx_q];
      last_q <= last_byte && frame_q.last_fin;
      err_q  <= frame_q.err;
    end
  end

  assign frame_byte_o = byte_q;
  assign last_o       = last_q;
  assign error_o      = err_q;
  assign out_valid_o  = out_vld_q;

endmodule
`default_nettype wire

/* hdl/modbus_tcp_request_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_tcp_request_framer
// Turns request and payload items into Modbus TCP request frame bytes.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// in       in   in_valid_i/in_ready_o  command, unit_id, address, quantity, value
// out      out  out_valid_o/out_ready_i frame_byte, last, error
//
// One byte leaves per cycle unless the output stalls: a request has 12 or 13
// bytes, a payload element 1 or 2, an error 1, as the frame register and its
// byte index set. The first byte passes the item, frame and byte registers.
// Reset clears the transaction counter and the pending payload count.
// A stalled output holds its byte; the next item is taken during the last byte.
// ----------------------------------------------------------------------------
module modbus_tcp_request_framer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [3:0]  command_i,
  input  wire  [7:0]  unit_id_i,
  input  wire  [15:0] address_i,
  input  wire  [15:0] quantity_i,
  input  wire  [15:0] value_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_o,
  output logic        error_o
);
  import mtrf_pkg::*;

  item_t  item_q;
  logic   in_vld_q;
  state_t state_q;
  state_t state_d;
  frame_t frame;
  logic   frame_rdy;
  logic   a_adv;

  assign a_adv      = in_vld_q && frame_rdy;
  assign in_ready_o = !in_vld_q || frame_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (a_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{command: command_i, unit_id: unit_id_i, address: address_i,
                  quantity: quantity_i, value: value_i};
    end
  end

  mtrf_decode u_decode (
    .item_i  (item_q),
    .state_i (state_q),
    .frame_o (frame),
    .state_o (state_d)
  );

  mtrf_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .frame_vld_i  (in_vld_q),
    .frame_rdy_o  (frame_rdy),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o),
    .error_o      (error_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o)
    else $error("error beat without last");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !frame_rdy |=> in_vld_q && $stable(item_q))
    else $error("held item changed while blocked");

  a_err_keeps_tc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && frame.err |=> $stable(state_q.tc))
    else $error("rejected item moved the transaction counter");

  a_ok_bumps_tc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && !frame.err && (item_q.command < CMD_PAYLOAD)
    |=> state_q.tc == $past(state_q.tc) + 16'd1)
    else $error("accepted request did not advance the counter");

endmodule
`default_nettype wire
